// ===== src/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg: shared types for the LFU key/value table
// Holds the command broadcast to the cells, the record passed along the
// cell chain, the sequencer states and the register index.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int IDX_MAX_BITS  = 6;   // up to 64 entries
   localparam int RANK_MAX_BITS = 7;   // ranks and the "above all" threshold
   localparam int CNT_MAX_BITS  = 32;  // widest supported use count

   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic CAPACITY_INDEX = 1'b0;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   // Update broadcast to every cell for one cycle.
   typedef struct packed {
      logic                     en;
      logic [IDX_MAX_BITS-1:0]  idx;
      logic [RANK_MAX_BITS-1:0] thr;      // valid entries below this rank age
      logic                     load;     // install a new entry at idx
      logic                     wr_data;  // overwrite data of a touched entry
      logic [31:0]              key;
      logic [31:0]              value;
   } cmd_type;

   // Running search result handed from cell to cell.
   typedef struct packed {
      logic                     hit;
      logic [IDX_MAX_BITS-1:0]  hit_idx;
      logic [RANK_MAX_BITS-1:0] hit_rank;
      logic [31:0]              hit_data;
      logic                     vic;
      logic [IDX_MAX_BITS-1:0]  vic_idx;
      logic [RANK_MAX_BITS-1:0] vic_rank;
      logic [CNT_MAX_BITS-1:0]  vic_cnt;
      logic [31:0]              vic_key;
      logic                     free;
      logic [IDX_MAX_BITS-1:0]  free_idx;
   } link_type;

endpackage

// ===== src/lfu_ifs.sv =====
// ----------------------------------------------------------------------------
// lfu_ifs: request and response channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lfu_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] key;
   logic [31:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] read_value;
   logic        evicted;
   logic [31:0] evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

// ===== src/lfu_cell.sv =====
// ----------------------------------------------------------------------------
// lfu_cell: one table entry
// Holds key, data, use count and recency rank; folds itself into the
// search record from its left neighbor and registers the result.
// ----------------------------------------------------------------------------
module lfu_cell #(
   parameter int INDEX      = 0,
   parameter int RANK_BITS  = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  lfu_pkg::cmd_type cmd,
   input  logic [31:0]      lookup_key,
   input  lfu_pkg::link_type link_in,
   output lfu_pkg::link_type link_out
);
   import lfu_pkg::*;

   localparam logic [IDX_MAX_BITS-1:0] MY_IDX = IDX_MAX_BITS'(INDEX);

   logic                  valid_ff;
   logic [31:0]           key_ff;
   logic [31:0]           data_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [RANK_BITS-1:0]  rank_ff;
   link_type              link_ff;
   link_type              link_in_c;

   logic [RANK_MAX_BITS-1:0] my_rank;
   logic [CNT_MAX_BITS-1:0]  my_cnt;

   assign my_rank = RANK_MAX_BITS'(rank_ff);
   assign my_cnt  = CNT_MAX_BITS'(cnt_ff);

   always_comb begin
      link_in_c = link_in;
      if (!link_in.hit && valid_ff && key_ff == lookup_key) begin
         link_in_c.hit      = 1'b1;
         link_in_c.hit_idx  = MY_IDX;
         link_in_c.hit_rank = my_rank;
         link_in_c.hit_data = data_ff;
      end
      if (!link_in.free && !valid_ff) begin
         link_in_c.free     = 1'b1;
         link_in_c.free_idx = MY_IDX;
      end
      if (valid_ff && (!link_in.vic || my_cnt < link_in.vic_cnt ||
                       (my_cnt == link_in.vic_cnt && my_rank > link_in.vic_rank))) begin
         link_in_c.vic      = 1'b1;
         link_in_c.vic_idx  = MY_IDX;
         link_in_c.vic_rank = my_rank;
         link_in_c.vic_cnt  = my_cnt;
         link_in_c.vic_key  = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_c;
      end
   end

   assign link_out = link_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.en) begin
         if (cmd.idx == MY_IDX) begin
            rank_ff <= '0;
            if (cmd.load) begin
               valid_ff <= 1'b1;
               key_ff   <= cmd.key;
               data_ff  <= cmd.value;
               cnt_ff   <= COUNT_BITS'(1);
            end else begin
               if (cnt_ff != {COUNT_BITS{1'b1}}) begin
                  cnt_ff <= cnt_ff + COUNT_BITS'(1);
               end
               if (cmd.wr_data) begin
                  data_ff <= cmd.value;
               end
            end
         end else if (valid_ff && my_rank < cmd.thr) begin
            rank_ff <= rank_ff + RANK_BITS'(1);
         end
      end
   end

endmodule

// ===== src/lfu_cache_table_core.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_table_core: least-frequently-used key/value table
// Get/set requests on 32-bit keys; sets evict the least used entry when full.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel carries one item per request: func (0 get, 1 set), key and
//    value. rsp returns exactly one item per request: hit, read_value (-1
//    unless a get hits), evicted and evicted_key (0 when nothing left).
//  - csr is an APB-style port with one register, capacity, at address 0.
//    Write it only while the table is idle. Zero acts as 1, values above
//    ENTRIES act as ENTRIES.
//  - Each entry lives in a cell of a chain. A search record ripples through
//    the chain one cell per cycle; the response is loaded once the record
//    leaves the last cell, and a new request is accepted only after that
//    response is loaded, so the chain length sets both.
//  - The response sits in an output register; the next request is accepted
//    while it waits. If the receiver stalls, the finished search holds until
//    the register frees, then the table updates and the response loads.
//  - Synchronous reset empties the table and sets capacity to 8.
// ----------------------------------------------------------------------------
module lfu_cache_table_core #(
   parameter int ENTRIES    = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   lfu_req_if.sink     req,
   lfu_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lfu_pkg::*;

   localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_BITS = $clog2(ENTRIES + 1);
   localparam int SCAN_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Configuration register.
   logic [6:0] capacity_ff;
   logic [6:0] cap_eff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CAPACITY_INDEX) ? {25'd0, capacity_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 7'd8;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CAPACITY_INDEX) begin
         capacity_ff <= csr_pwdata[6:0];
      end
   end

   always_comb begin
      if (capacity_ff == 7'd0) begin
         cap_eff = 7'd1;
      end else if (capacity_ff > 7'(ENTRIES)) begin
         cap_eff = 7'(ENTRIES);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   // Request latch and sequencer.
   state_type             state_ff, state_in;
   logic [SCAN_BITS-1:0]  scan_ff, scan_in;
   logic                  func_ff;
   logic [31:0]           key_ff;
   logic [31:0]           value_ff;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic                  fire;

   logic                  rsp_valid_ff;
   logic                  hit_ff;
   logic [31:0]           read_value_ff;
   logic                  evicted_ff;
   logic [31:0]           evicted_key_ff;

   cmd_type               cmd;
   link_type              links [ENTRIES+1];
   link_type              result;
   logic                  need_evict;

   assign req.ready = (state_ff == ST_IDLE);
   assign links[0]  = '0;
   assign result    = links[ENTRIES];
   assign need_evict = 7'(fill_ff) >= cap_eff;

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      fire     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (req.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + SCAN_BITS'(1);
            if (scan_ff == SCAN_BITS'(ENTRIES - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // hold the search result until the output register frees
            if (!rsp_valid_ff || rsp.ready) begin
               fire     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         func_ff  <= req.func;
         key_ff   <= req.key;
         value_ff <= req.value;
      end
   end

   // Build the table update from the finished search.
   always_comb begin
      cmd         = '0;
      cmd.key     = key_ff;
      cmd.value   = value_ff;
      fill_in     = fill_ff;
      if (fire) begin
         if (result.hit) begin
            // touch: entries more recent than the hit age by one
            cmd.en      = 1'b1;
            cmd.idx     = result.hit_idx;
            cmd.thr     = result.hit_rank;
            cmd.wr_data = (func_ff == FUNC_SET);
         end else if (func_ff == FUNC_SET) begin
            cmd.en   = 1'b1;
            cmd.load = 1'b1;
            if (need_evict) begin
               // reuse the victim slot; only entries newer than it age
               cmd.idx = result.vic_idx;
               cmd.thr = result.vic_rank;
            end else begin
               cmd.idx = result.free_idx;
               cmd.thr = RANK_MAX_BITS'(ENTRIES);
               fill_in = fill_ff + FILL_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         hit_ff         <= result.hit;
         read_value_ff  <= (result.hit && func_ff == FUNC_GET) ? result.hit_data : MISS_VALUE;
         evicted_ff     <= !result.hit && func_ff == FUNC_SET && need_evict;
         evicted_key_ff <= (!result.hit && func_ff == FUNC_SET && need_evict) ?
                           result.vic_key : 32'd0;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = hit_ff;
   assign rsp.read_value  = read_value_ff;
   assign rsp.evicted     = evicted_ff;
   assign rsp.evicted_key = evicted_key_ff;

   // Cell chain.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lfu_cell #(
         .INDEX      (g),
         .RANK_BITS  (RANK_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .lookup_key (key_ff),
         .link_in    (links[g]),
         .link_out   (links[g+1])
      );
   end

endmodule
